[hw/rtl/pll_divider_solver_core_defines.svh]
// Assertion macros for the port-level checker (pds_checker) of the PLL divider solver.
// Depends on nothing; the including scope must provide clock and reset.
`ifndef PLL_DIVIDER_SOLVER_CORE_DEFINES_SVH
`define PLL_DIVIDER_SOLVER_CORE_DEFINES_SVH

// same-cycle implication, off while reset is high
`define PDS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pds check failed");

// next-cycle implication, off while reset is high
`define PDS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pds check failed");

`endif

[hw/rtl/pds_pkg.sv]
// Types and fixed constants of the PLL divider solver.
// Depends on nothing; used by the core, the divider and the checker.
`default_nettype none

package pds_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRECHK,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_DIV,
      ST_CNEXT,
      ST_PNEXT,
      ST_DONE
   } state_type;

   localparam logic [1:0] CODE_OK      = 2'd0;
   localparam logic [1:0] CODE_INVALID = 2'd1;
   localparam logic [1:0] CODE_NOFIT   = 2'd2;

   localparam int unsigned REF_W  = 32;
   localparam int unsigned WANT_W = 30;

   localparam logic [25:0] PLL_IN_MIN_HZ = 26'd5000000;
   localparam logic [25:0] PLL_IN_MAX_HZ = 26'd64000000;
   localparam logic [30:0] VCO_MIN_HZ    = 31'd500000000;
   localparam logic [30:0] VCO_MAX_HZ    = 31'd1600000000;
   localparam logic [29:0] OUT_MAX_HZ    = 30'd800000000;
   localparam logic [8:0]  FB_MIN        = 9'd16;
   localparam logic [8:0]  FB_MAX        = 9'd400;

endpackage

`default_nettype wire

[hw/rtl/pds_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on pds_pkg for the divisor width.
`default_nettype none

module pds_divider
   import pds_pkg::*;
#(
   parameter int unsigned NUM_W = 40
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [NUM_W-1:0]   dividend,
   input  wire logic [REF_W-1:0]   divisor,
   output logic                    done,
   output logic [NUM_W-1:0]        quotient,
   output logic                    rem_zero
);

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic               run_ff,  run_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff,  cnt_in;
   logic [REF_W-1:0]   rem_ff,  rem_in;
   logic [NUM_W-1:0]   quo_ff,  quo_in;
   logic [REF_W:0]     trial;
   logic               fits;

   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      fits  = (trial >= {1'b0, divisor});
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(NUM_W);
         rem_in = '0;
         quo_in = dividend;
      end else if (run_ff) begin
         // shift the next dividend bit in, keep the difference when it fits
         rem_in = fits ? REF_W'(trial - {1'b0, divisor}) : trial[REF_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

`default_nettype wire

[hw/rtl/pll_divider_solver_core.sv]
// PLL divider solver: searches pre, post and feedback dividers for an exact output.
// Depends on pds_pkg and pds_divider.
// Raise start with both frequencies while busy is low; busy then stays high until the
// single result word shows on the rsp_ ports for one cycle with rsp_valid, and that word
// must be taken right then since the block cannot be held off. Zero operands and
// targets above 800 MHz answer in the cycle right after the word is taken. A search
// walks pre-divider 1..PRE_DIV_MAX, checking each against the PLL input range, and tries
// post divider pairs in turn on one shared multiplier; pairs whose VCO lands in window
// add the serial divider (NUM_W = 30 + pre bits + 2 * post bits, 40 by default).
`default_nettype none

module pll_divider_solver_core
   import pds_pkg::*;
#(
   parameter int unsigned PRE_DIV_MAX  = 15,
   parameter int unsigned POST_DIV_MAX = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic [31:0]   req_ref_freq_hz,
   input  wire logic [31:0]   req_want_freq_hz,
   output logic               rsp_valid,
   output logic [1:0]         rsp_result_code,
   output logic [8:0]         rsp_fb_divide,
   output logic [3:0]         rsp_pre_divide,
   output logic [2:0]         rsp_post_divide_one,
   output logic [2:0]         rsp_post_divide_two,
   output logic [29:0]        rsp_out_freq_hz
);

   localparam int unsigned PRE_W  = $clog2(PRE_DIV_MAX + 1);
   localparam int unsigned POST_W = $clog2(POST_DIV_MAX + 1);
   localparam int unsigned MB_W   = (PRE_W > POST_W) ? PRE_W : POST_W;
   localparam int unsigned NUM_W  = WANT_W + PRE_W + 2 * POST_W;
   localparam int unsigned LIM_W  = REF_W + PRE_W;

   state_type            state_ff, state_in;
   logic [REF_W-1:0]     ref_ff,   ref_in;
   logic [WANT_W-1:0]    want_ff,  want_in;
   logic [PRE_W-1:0]     pre_ff,   pre_in;
   logic [POST_W-1:0]    p1_ff,    p1_in;
   logic [POST_W-1:0]    p2_ff,    p2_in;
   logic [8:0]           fb_ff,    fb_in;
   logic [1:0]           code_ff,  code_in;
   logic [NUM_W-1:0]     prod_ff,  prod_in;

   logic                 accept;
   logic                 in_zero, in_high;
   logic [LIM_W-1:0]     lim_lo, lim_hi;
   logic                 pre_ok;
   logic [NUM_W-1:0]     mul_a, mul_res;
   logic [MB_W-1:0]      mul_b;
   logic                 vco_ok;
   logic                 div_start, div_done, div_rem_zero;
   logic [NUM_W-1:0]     div_quo;
   logic                 fb_ok;

   assign accept  = start && (state_ff == ST_IDLE);
   assign in_zero = (req_ref_freq_hz == '0) || (req_want_freq_hz == '0);
   assign in_high = (req_want_freq_hz > {2'b00, OUT_MAX_HZ});

   assign lim_lo = LIM_W'(PLL_IN_MIN_HZ) * LIM_W'(pre_ff);
   assign lim_hi = LIM_W'(PLL_IN_MAX_HZ) * LIM_W'(pre_ff);
   assign pre_ok = (LIM_W'(ref_ff) >= lim_lo) && (LIM_W'(ref_ff) <= lim_hi);

   // shared multiplier: want*p2, then *p1, then *pre
   always_comb begin
      unique case (state_ff)
         ST_MUL1: begin
            mul_a = NUM_W'(want_ff);
            mul_b = MB_W'(p2_ff);
         end
         ST_MUL2: begin
            mul_a = prod_ff;
            mul_b = MB_W'(p1_ff);
         end
         ST_MUL3: begin
            mul_a = prod_ff;
            mul_b = MB_W'(pre_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_res = NUM_W'(mul_a * NUM_W'(mul_b));

   // exact fit means ref*fb equals the product, so the VCO (ref*fb over pre) is want*p1*p2
   assign vco_ok = (mul_res >= NUM_W'(VCO_MIN_HZ)) && (mul_res <= NUM_W'(VCO_MAX_HZ));

   assign div_start = (state_ff == ST_MUL3);

   pds_divider #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_res),
      .divisor  (ref_ff),
      .done     (div_done),
      .quotient (div_quo),
      .rem_zero (div_rem_zero)
   );

   assign fb_ok = div_rem_zero && (div_quo >= NUM_W'(FB_MIN)) && (div_quo <= NUM_W'(FB_MAX));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (in_zero || in_high) ? ST_DONE : ST_PRECHK;
            end
         end
         ST_PRECHK: state_in = pre_ok ? ST_MUL1 : ST_PNEXT;
         ST_MUL1:   state_in = ST_MUL2;
         ST_MUL2:   state_in = vco_ok ? ST_MUL3 : ST_CNEXT;
         ST_MUL3:   state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = fb_ok ? ST_DONE : ST_CNEXT;
            end
         end
         ST_CNEXT: begin
            if ((p1_ff != POST_W'(POST_DIV_MAX)) || (p2_ff != POST_W'(POST_DIV_MAX))) begin
               state_in = ST_MUL1;
            end else begin
               state_in = ST_PNEXT;
            end
         end
         ST_PNEXT:  state_in = (pre_ff != PRE_W'(PRE_DIV_MAX)) ? ST_PRECHK : ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      ref_in  = ref_ff;
      want_in = want_ff;
      pre_in  = pre_ff;
      p1_in   = p1_ff;
      p2_in   = p2_ff;
      fb_in   = fb_ff;
      code_in = code_ff;
      prod_in = prod_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ref_in  = req_ref_freq_hz;
               want_in = req_want_freq_hz[WANT_W-1:0];
               pre_in  = PRE_W'(1);
               code_in = in_zero ? CODE_INVALID : CODE_NOFIT;
            end
         end
         ST_PRECHK: begin
            p1_in = POST_W'(1);
            p2_in = POST_W'(1);
         end
         ST_MUL1, ST_MUL2, ST_MUL3: prod_in = mul_res;
         ST_DIV: begin
            if (div_done && fb_ok) begin
               fb_in   = div_quo[8:0];
               code_in = CODE_OK;
            end
         end
         ST_CNEXT: begin
            if (p1_ff != POST_W'(POST_DIV_MAX)) begin
               p1_in = p1_ff + POST_W'(1);
            end else if (p2_ff != POST_W'(POST_DIV_MAX)) begin
               // restart post1 at the new post2
               p2_in = p2_ff + POST_W'(1);
               p1_in = p2_ff + POST_W'(1);
            end
         end
         ST_PNEXT: begin
            if (pre_ff != PRE_W'(PRE_DIV_MAX)) begin
               pre_in = pre_ff + PRE_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         code_ff  <= CODE_NOFIT;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
      ref_ff  <= ref_in;
      want_ff <= want_in;
      pre_ff  <= pre_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      fb_ff   <= fb_in;
      prod_ff <= prod_in;
   end

   // outputs
   always_comb begin
      busy                = (state_ff != ST_IDLE);
      rsp_valid           = (state_ff == ST_DONE);
      rsp_result_code     = code_ff;
      rsp_fb_divide       = '0;
      rsp_pre_divide      = '0;
      rsp_post_divide_one = '0;
      rsp_post_divide_two = '0;
      rsp_out_freq_hz     = '0;
      if (code_ff == CODE_OK) begin
         rsp_fb_divide       = fb_ff;
         rsp_pre_divide      = 4'(pre_ff);
         rsp_post_divide_one = 3'(p1_ff);
         rsp_post_divide_two = 3'(p2_ff);
         rsp_out_freq_hz     = want_ff;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/pds_checker.sv]
// Port-level checks of the PLL divider solver, bound to the top level.
// Depends on pds_pkg and pll_divider_solver_core_defines.svh.
`default_nettype none
`include "pll_divider_solver_core_defines.svh"

module pds_checker
   import pds_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          busy,
   input  wire logic [31:0]   req_ref_freq_hz,
   input  wire logic [31:0]   req_want_freq_hz,
   input  wire logic          rsp_valid,
   input  wire logic [1:0]    rsp_result_code,
   input  wire logic [8:0]    rsp_fb_divide,
   input  wire logic [3:0]    rsp_pre_divide,
   input  wire logic [2:0]    rsp_post_divide_one,
   input  wire logic [2:0]    rsp_post_divide_two,
   input  wire logic [29:0]   rsp_out_freq_hz
);

   logic in_word_zero;
   logic fail_fields_zero;

   assign in_word_zero = (req_ref_freq_hz == '0) || (req_want_freq_hz == '0);
   assign fail_fields_zero = (rsp_fb_divide == '0) && (rsp_pre_divide == '0) &&
                             (rsp_post_divide_one == '0) && (rsp_post_divide_two == '0) &&
                             (rsp_out_freq_hz == '0);

   `PDS_ASSERT_NEXT(a_take_goes_busy, start && !busy, busy)
   `PDS_ASSERT_NEXT(a_word_ends_busy, rsp_valid, !busy)
   `PDS_ASSERT_NOW(a_ok_fb_range, rsp_valid && (rsp_result_code == CODE_OK),
      (rsp_fb_divide >= FB_MIN) && (rsp_fb_divide <= FB_MAX) &&
      (rsp_post_divide_one >= rsp_post_divide_two) && (rsp_post_divide_two != '0))
   `PDS_ASSERT_NOW(a_fail_zero, rsp_valid && (rsp_result_code != CODE_OK), fail_fields_zero)
   `PDS_ASSERT_NEXT(a_zero_fast, start && !busy && in_word_zero,
      rsp_valid && (rsp_result_code == CODE_INVALID))

endmodule

bind pll_divider_solver_core pds_checker u_pds_checker (.*);

`default_nettype wire

[dv/pll_divider_checker.sv]
`timescale 1ns / 100ps
// Checker for the PLL divider solver: predicts each result word from the request
// and compares it with what comes out. Depends on pds_pkg only.
`default_nettype none

module pll_divider_checker
   import pds_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [31:0] req_ref_freq_hz,
   input  wire logic [31:0] req_want_freq_hz,
   input  wire logic        rsp_valid,
   input  wire logic [1:0]  rsp_result_code,
   input  wire logic [8:0]  rsp_fb_divide,
   input  wire logic [3:0]  rsp_pre_divide,
   input  wire logic [2:0]  rsp_post_divide_one,
   input  wire logic [2:0]  rsp_post_divide_two,
   input  wire logic [29:0] rsp_out_freq_hz,
   output int               fail_count,
   output int               pending_count
);

   localparam int unsigned PRE_LIMIT  = 15;
   localparam int unsigned POST_LIMIT = 7;

   typedef struct packed {
      logic [1:0]  code;
      logic [8:0]  fb;
      logic [3:0]  pre;
      logic [2:0]  post1;
      logic [2:0]  post2;
      logic [29:0] freq;
   } divider_set_type;

   divider_set_type expected_sets[$];

   function automatic divider_set_type solve_dividers(logic [31:0] ref_hz,
                                                      logic [31:0] want_hz);
      divider_set_type s;
      logic [63:0] num, fb, vco;
      s = '0;
      if (ref_hz == 0 || want_hz == 0) begin
         s.code = CODE_INVALID;
         return s;
      end
      s.code = CODE_NOFIT;
      if (want_hz > 32'd800000000) return s;
      for (int unsigned pre = 1; pre <= PRE_LIMIT; pre++) begin
         if (64'(ref_hz) < 64'd5000000 * pre || 64'(ref_hz) > 64'd64000000 * pre) continue;
         for (int unsigned p2 = 1; p2 <= POST_LIMIT; p2++) begin
            for (int unsigned p1 = p2; p1 <= POST_LIMIT; p1++) begin
               num = 64'(want_hz) * pre * p1 * p2;
               if (num % ref_hz != 0) continue;
               fb = num / ref_hz;
               if (fb < 16 || fb > 400) continue;
               vco = 64'(ref_hz) * fb;
               if (vco < 64'd500000000 * pre || vco > 64'd1600000000 * pre) continue;
               s.code  = CODE_OK;
               s.fb    = fb[8:0];
               s.pre   = pre[3:0];
               s.post1 = p1[2:0];
               s.post2 = p2[2:0];
               s.freq  = want_hz[29:0];
               return s;
            end
         end
      end
      return s;
   endfunction

   assign pending_count = expected_sets.size();

   always @(posedge clock) begin
      divider_set_type want_set;
      if (reset) begin
         fail_count <= 0;
         expected_sets.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_sets.size() == 0) begin
               $error("result word with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want_set = expected_sets.pop_front();
               if (rsp_result_code !== want_set.code ||
                   rsp_fb_divide !== want_set.fb ||
                   rsp_pre_divide !== want_set.pre ||
                   rsp_post_divide_one !== want_set.post1 ||
                   rsp_post_divide_two !== want_set.post2 ||
                   rsp_out_freq_hz !== want_set.freq)
                  fail_count <= fail_count + 1;
               if (rsp_result_code !== want_set.code)
                  $error("result_code exp %0d got %0d", want_set.code, rsp_result_code);
               if (rsp_fb_divide !== want_set.fb)
                  $error("fb_divide exp %0d got %0d", want_set.fb, rsp_fb_divide);
               if (rsp_pre_divide !== want_set.pre)
                  $error("pre_divide exp %0d got %0d", want_set.pre, rsp_pre_divide);
               if (rsp_post_divide_one !== want_set.post1)
                  $error("post_divide_one exp %0d got %0d", want_set.post1,
                         rsp_post_divide_one);
               if (rsp_post_divide_two !== want_set.post2)
                  $error("post_divide_two exp %0d got %0d", want_set.post2,
                         rsp_post_divide_two);
               if (rsp_out_freq_hz !== want_set.freq)
                  $error("out_freq_hz exp %0d got %0d", want_set.freq, rsp_out_freq_hz);
            end
         end
         if (start && !busy)
            expected_sets.push_back(solve_dividers(req_ref_freq_hz, req_want_freq_hz));
      end
   end

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for the PLL divider solver: drives frequency pairs and gives the verdict.
// Depends on pds_pkg, pll_divider_solver_core and pll_divider_checker.
`default_nettype none

module tb_top
   import pds_pkg::*;
;

   localparam int WATCHDOG_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [31:0] req_ref_freq_hz = '0;
   logic [31:0] req_want_freq_hz = '0;
   logic        busy, rsp_valid;
   logic [1:0]  rsp_result_code;
   logic [8:0]  rsp_fb_divide;
   logic [3:0]  rsp_pre_divide;
   logic [2:0]  rsp_post_divide_one, rsp_post_divide_two;
   logic [29:0] rsp_out_freq_hz;
   int          fail_count, pending_count;
   int          quiet_cycles = 0;
   bit          calm_stretch = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   pll_divider_solver_core u_top (.*);

   pll_divider_checker u_checker (.*);

   // count cycles with no word moving on either side
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_word(logic [31:0] ref_hz, logic [31:0] want_hz);
      // step off the edge where start was last dropped
      @(posedge clock);
      while (!calm_stretch && $urandom_range(99) < 10) @(posedge clock);
      start            <= 1'b1;
      req_ref_freq_hz  <= ref_hz;
      req_want_freq_hz <= want_hz;
      do @(posedge clock); while (busy);
      start <= 1'b0;
   endtask

   // pick a pair built from a real divider set, so most words find a fit
   task automatic send_solvable();
      logic [31:0] ref_hz;
      int unsigned pre, p1, p2, fb;
      pre = $urandom_range(1, 15);
      p2  = $urandom_range(1, 7);
      p1  = $urandom_range(p2, 7);
      fb  = $urandom_range(16, 400);
      ref_hz = 32'($urandom_range(5, 64)) * 1000000 * pre / $urandom_range(1, 4);
      send_word(ref_hz, 32'(64'(ref_hz) * fb / (pre * p1 * p2)));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corners
      send_word(32'd0, 32'd100000000);
      send_word(32'd10000000, 32'd0);
      send_word(32'd0, 32'd0);
      send_word(32'hFFFFFFFF, 32'hFFFFFFFF);
      send_word(32'd10000000, 32'd800000001);
      send_word(32'd10000000, 32'd800000000);
      send_word(32'd5000000, 32'd100000000);
      send_word(32'd64000000, 32'd200000000);
      send_word(32'd4999999, 32'd100000000);
      send_word(32'd960000000, 32'd100000000);
      send_word(32'd10000000, 32'd500000000);
      send_word(32'd10000000, 32'd1600000000 / 49);
      send_word(32'd10000000, 32'd12345679);
      send_word(32'd24000000, 32'd1);
      send_word(32'd1, 32'd1);
      send_word(32'd12000000, 32'd400000000);
      // hold off until everything is answered
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      for (int i = 0; i < 100; i++) begin
         calm_stretch = (i >= 40 && i < 60);
         if ($urandom_range(99) < 70) send_solvable();
         else if ($urandom_range(1)) send_word($urandom, $urandom);
         else send_word($urandom_range(1, 100000000), $urandom_range(1, 900000000));
      end
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
